// File: sv/sfd_pkg.sv
// shared types and constants for the sbus frame decoder
package sfd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int NUM_CH      = 10;
  localparam int NUM_SW      = 6;
  localparam int CH_BITS     = 11;
  localparam int VAL_BITS    = 12;
  localparam int FLAG_BITS   = 13;
  localparam int SW_FIRST_CH = 4;

  localparam logic [7:0] SBUS_HEADER = 8'h0F;
  localparam logic [7:0] SBUS_FOOTER = 8'h00;

  typedef logic signed [VAL_BITS-1:0] chan_t;

  typedef enum logic [1:0] {
    POS_UP  = 2'd0,
    POS_MID = 2'd1,
    POS_DN  = 2'd2
  } sw_pos_t;

  typedef enum logic [1:0] {
    REG_CHANNEL_OFFSET    = 2'd0,
    REG_SWITCH_LOW_LIMIT  = 2'd1,
    REG_SWITCH_HIGH_LIMIT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [NUM_CH-1:0][VAL_BITS-1:0] ch;
    logic [FLAG_BITS-1:0]            key_flags;
  } result_t;

endpackage

// File: sv/sfd_in_if.sv
// input channel: received bytes and idle-line events
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// File: sv/sfd_out_if.sv
// output channel: decoded channels and key flags
interface sfd_out_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] stick_right_x;
  logic signed [11:0] stick_right_y;
  logic signed [11:0] stick_left_y;
  logic signed [11:0] stick_left_x;
  logic signed [11:0] switch_a_value;
  logic signed [11:0] switch_b_value;
  logic signed [11:0] switch_c_value;
  logic signed [11:0] switch_d_value;
  logic signed [11:0] switch_e_value;
  logic signed [11:0] switch_f_value;
  logic        [12:0] key_flags;

  modport source (
    output valid, input ready,
    output stick_right_x, output stick_right_y, output stick_left_y, output stick_left_x,
    output switch_a_value, output switch_b_value, output switch_c_value,
    output switch_d_value, output switch_e_value, output switch_f_value,
    output key_flags
  );
  modport sink (
    input valid, output ready,
    input stick_right_x, input stick_right_y, input stick_left_y, input stick_left_x,
    input switch_a_value, input switch_b_value, input switch_c_value,
    input switch_d_value, input switch_e_value, input switch_f_value,
    input key_flags
  );
endinterface

// File: sv/sbus_frame_decoder_with_switch_keys_top.sv
// sbus frame decoder top level: byte chain, frame check, decode and output buffer
//
// rx_in carries one word per byte (func 0) or an idle-line event (func 1).
// bytes shift into a chain of 25 byte cells; the count saturates at
// RX_BUFFER_BYTES. an idle event closes the frame: with exactly 25 bytes,
// header 0x0f and footer 0x00 the ten channels are unpacked, offset and
// classified, and one word appears on res_out; otherwise nothing is sent.
// cfg_we/cfg_index/cfg_data write channel_offset, switch_low_limit and
// switch_high_limit; the user is to make writes only while the block is idle;
// the block does not enforce this. throughput is one input word per cycle
// while rx_ready is high. a result is registered on the edge that takes the
// idle event. the output register plus one skid register keep rx_in ready
// while a result waits; rx_ready drops only once the skid register is full
// as well. reset (rst, synchronous) clears the count, the output valids, restores
// the register defaults and the switch history (a, b, e, f up; c, d mid).
module sbus_frame_decoder_with_switch_keys_top #(
  parameter int RX_BUFFER_BYTES = 36
) (
  input  logic               clk,
  input  logic               rst,
  sfd_in_if.sink             rx_in,
  sfd_out_if.source          res_out,
  input  logic               cfg_we,
  input  sfd_pkg::cfg_reg_t  cfg_index,
  input  logic [11:0]        cfg_data
);
  import sfd_pkg::*;

  localparam int CntW = $clog2(RX_BUFFER_BYTES + 1);

  logic [CntW-1:0]            count;
  logic [7:0]                 frame [FRAME_BYTES];
  logic [CH_BITS-1:0]         channel_offset;
  logic signed [VAL_BITS-1:0] switch_low_limit;
  logic signed [VAL_BITS-1:0] switch_high_limit;
  sw_pos_t                    last_pos [NUM_SW];
  sw_pos_t                    pos [NUM_SW];
  result_t                    result;
  result_t                    out_data;
  result_t                    skid_data;
  logic                       out_valid;
  logic                       skid_valid;
  logic                       acc;
  logic                       shift_en;
  logic                       frame_ok;
  logic                       out_stall;

  assign rx_in.ready = !skid_valid;
  assign acc         = rx_in.valid && rx_in.ready;
  assign shift_en    = acc && !rx_in.func && count < CntW'(FRAME_BYTES);
  assign frame_ok    = acc && rx_in.func && count == CntW'(FRAME_BYTES)
                    && frame[0] == SBUS_HEADER && frame[FRAME_BYTES-1] == SBUS_FOOTER;
  assign out_stall   = out_valid && !res_out.ready;

  // newest byte enters at the top cell, the first byte ends up in cell zero
  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    if (i == FRAME_BYTES - 1) begin : g_top
      sfd_byte_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (rx_in.rx_byte),
        .q     (frame[i])
      );
    end else begin : g_mid
      sfd_byte_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (frame[i+1]),
        .q     (frame[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      if (rx_in.func) begin
        count <= '0;
      end else if (count < CntW'(RX_BUFFER_BYTES)) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_offset    <= 11'd1024;
      switch_low_limit  <= -12'sd600;
      switch_high_limit <= 12'sd600;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_OFFSET:    channel_offset    <= cfg_data[CH_BITS-1:0];
        REG_SWITCH_LOW_LIMIT:  switch_low_limit  <= $signed(cfg_data);
        REG_SWITCH_HIGH_LIMIT: switch_high_limit <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  sfd_decoder u_decoder (
    .frame             (frame),
    .channel_offset    (channel_offset),
    .switch_low_limit  (switch_low_limit),
    .switch_high_limit (switch_high_limit),
    .last_pos          (last_pos),
    .pos               (pos),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pos[0] <= POS_UP;
      last_pos[1] <= POS_UP;
      last_pos[2] <= POS_MID;
      last_pos[3] <= POS_MID;
      last_pos[4] <= POS_UP;
      last_pos[5] <= POS_UP;
    end else if (frame_ok) begin
      last_pos <= pos;
    end
  end

  // skid is only filled while the output word is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (frame_ok) begin
      if (out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_valid && res_out.ready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_ok && !out_stall) begin
      out_data <= result;
    end else if (out_valid && res_out.ready && skid_valid) begin
      out_data <= skid_data;
    end
    if (frame_ok && out_stall) begin
      skid_data <= result;
    end
  end

  assign res_out.valid          = out_valid;
  assign res_out.stick_right_x  = $signed(out_data.ch[0]);
  assign res_out.stick_right_y  = $signed(out_data.ch[1]);
  assign res_out.stick_left_y   = $signed(out_data.ch[2]);
  assign res_out.stick_left_x   = $signed(out_data.ch[3]);
  assign res_out.switch_a_value = $signed(out_data.ch[4]);
  assign res_out.switch_b_value = $signed(out_data.ch[5]);
  assign res_out.switch_c_value = $signed(out_data.ch[6]);
  assign res_out.switch_d_value = $signed(out_data.ch[7]);
  assign res_out.switch_e_value = $signed(out_data.ch[8]);
  assign res_out.switch_f_value = $signed(out_data.ch[9]);
  assign res_out.key_flags      = out_data.key_flags;
endmodule

// File: sv/sfd_byte_cell.sv
// one byte cell of the frame shift chain
module sfd_byte_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end
endmodule

// File: sv/sfd_decoder.sv
// unpacks the channels of a frame, classifies switches and builds key flags
module sfd_decoder (
  input  logic [7:0]                          frame [sfd_pkg::FRAME_BYTES],
  input  logic [sfd_pkg::CH_BITS-1:0]         channel_offset,
  input  logic signed [sfd_pkg::VAL_BITS-1:0] switch_low_limit,
  input  logic signed [sfd_pkg::VAL_BITS-1:0] switch_high_limit,
  input  sfd_pkg::sw_pos_t                    last_pos [sfd_pkg::NUM_SW],
  output sfd_pkg::sw_pos_t                    pos [sfd_pkg::NUM_SW],
  output sfd_pkg::result_t                    result
);
  import sfd_pkg::*;

  logic [(FRAME_BYTES-2)*8-1:0] payload;
  chan_t                        ch [NUM_CH];

  // payload bits start at byte one, lsb first
  always_comb begin
    for (int b = 1; b < FRAME_BYTES - 1; b++) begin
      payload[(b-1)*8 +: 8] = frame[b];
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      ch[k] = $signed({1'b0, payload[k*CH_BITS +: CH_BITS]})
            - $signed({1'b0, channel_offset});
    end
  end

  // up test wins when the limits cross
  always_comb begin
    for (int s = 0; s < NUM_SW; s++) begin
      if (ch[SW_FIRST_CH + s] <= switch_low_limit) begin
        pos[s] = POS_UP;
      end else if (ch[SW_FIRST_CH + s] >= switch_high_limit) begin
        pos[s] = POS_DN;
      end else begin
        pos[s] = POS_MID;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      result.ch[k] = ch[k];
    end
    result.key_flags[0]  = pos[0] == POS_UP;
    result.key_flags[1]  = pos[0] == POS_DN;
    result.key_flags[2]  = pos[1] == POS_UP;
    result.key_flags[3]  = pos[1] == POS_DN;
    result.key_flags[4]  = pos[2] == POS_UP;
    result.key_flags[5]  = pos[2] == POS_MID && last_pos[2] == POS_MID;
    result.key_flags[6]  = pos[2] == POS_DN;
    result.key_flags[7]  = pos[3] == POS_UP;
    result.key_flags[8]  = pos[3] == POS_MID && last_pos[3] == POS_MID;
    result.key_flags[9]  = pos[3] == POS_DN;
    result.key_flags[10] = pos[4] == POS_UP;
    result.key_flags[11] = pos[4] == POS_DN;
    // f reports the up to down edge only
    result.key_flags[12] = last_pos[5] == POS_UP && pos[5] == POS_DN;
  end
endmodule
